>>> rtl/gn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gn_pkg;

  localparam logic [31:0] PRIME_X  = 32'd501125321;
  localparam logic [31:0] PRIME_Y  = 32'd1136930381;
  localparam logic [31:0] PRIME_Z  = 32'd1720413743;
  localparam logic [31:0] HASH_MUL = 32'h27d4eb2d;
  localparam logic [16:0] SCALE_2D = 17'd93374;
  localparam logic [16:0] SCALE_3D = 17'd63237;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_MODE = 2'd1;

  localparam int GA = 4277;
  localparam int GB = 12540;
  localparam int GC = 19948;
  localparam int GD = 25997;
  localparam int GE = 30274;
  localparam int GF = 32488;

  typedef logic signed [15:0] grad_t;

  typedef struct packed {
    grad_t gx;
    grad_t gy;
  } grad2_t;

  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
    logic signed [1:0] gz;
  } grad3_t;

  // 2D gradient lookup from a 7-bit hash code
  function automatic grad2_t grad2_lookup(input logic [6:0] p);
    int a;
    int b;
    logic [6:0] i;
    logic [1:0] q;
    grad2_t g;
    a = 0;
    b = 0;
    i = p;
    q = 2'd0;
    if (p < 7'd120) begin
      // reduce modulo 24 by compare and subtract
      if (i >= 7'd96) i = i - 7'd96;
      if (i >= 7'd48) i = i - 7'd48;
      if (i >= 7'd24) i = i - 7'd24;
      // split into quadrant and entry within the quadrant
      if (i >= 7'd18) begin
        q = 2'd3;
        i = i - 7'd18;
      end else if (i >= 7'd12) begin
        q = 2'd2;
        i = i - 7'd12;
      end else if (i >= 7'd6) begin
        q = 2'd1;
        i = i - 7'd6;
      end else begin
        q = 2'd0;
      end
      unique case (i[2:0])
        3'd0: begin a = GA; b = GF; end
        3'd1: begin a = GB; b = GE; end
        3'd2: begin a = GC; b = GD; end
        3'd3: begin a = GD; b = GC; end
        3'd4: begin a = GE; b = GB; end
        default: begin a = GF; b = GA; end
      endcase
      unique case (q)
        2'd0: begin g.gx = grad_t'(a); g.gy = grad_t'(b); end
        2'd1: begin g.gx = grad_t'(b); g.gy = grad_t'(-a); end
        2'd2: begin g.gx = grad_t'(-a); g.gy = grad_t'(-b); end
        default: begin g.gx = grad_t'(-b); g.gy = grad_t'(a); end
      endcase
    end else begin
      unique case (p[2:0])
        3'd0: begin g.gx = grad_t'(GB); g.gy = grad_t'(GE); end
        3'd1: begin g.gx = grad_t'(GE); g.gy = grad_t'(GB); end
        3'd2: begin g.gx = grad_t'(GE); g.gy = grad_t'(-GB); end
        3'd3: begin g.gx = grad_t'(GB); g.gy = grad_t'(-GE); end
        3'd4: begin g.gx = grad_t'(-GB); g.gy = grad_t'(-GE); end
        3'd5: begin g.gx = grad_t'(-GE); g.gy = grad_t'(-GB); end
        3'd6: begin g.gx = grad_t'(-GE); g.gy = grad_t'(GB); end
        default: begin g.gx = grad_t'(-GB); g.gy = grad_t'(GE); end
      endcase
    end
    return g;
  endfunction

  // 3D gradient lookup from a 6-bit hash code
  function automatic grad3_t grad3_lookup(input logic [5:0] p);
    grad3_t g;
    logic [3:0] i;
    logic [5:0] r;
    i = 4'd0;
    r = p;
    if (p < 6'd60) begin
      // reduce modulo 12 by compare and subtract
      if (r >= 6'd48) r = r - 6'd48;
      if (r >= 6'd24) r = r - 6'd24;
      if (r >= 6'd12) r = r - 6'd12;
      i = r[3:0];
    end else begin
      unique case (p[1:0])
        2'd0: i = 4'd8;
        2'd1: i = 4'd1;
        2'd2: i = 4'd9;
        default: i = 4'd3;
      endcase
    end
    unique case (i)
      4'd0: g = '{2'sd0, 2'sd1, 2'sd1};
      4'd1: g = '{2'sd0, -2'sd1, 2'sd1};
      4'd2: g = '{2'sd0, 2'sd1, -2'sd1};
      4'd3: g = '{2'sd0, -2'sd1, -2'sd1};
      4'd4: g = '{2'sd1, 2'sd0, 2'sd1};
      4'd5: g = '{-2'sd1, 2'sd0, 2'sd1};
      4'd6: g = '{2'sd1, 2'sd0, -2'sd1};
      4'd7: g = '{-2'sd1, 2'sd0, -2'sd1};
      4'd8: g = '{2'sd1, 2'sd1, 2'sd0};
      4'd9: g = '{-2'sd1, 2'sd1, 2'sd0};
      4'd10: g = '{2'sd1, -2'sd1, 2'sd0};
      default: g = '{-2'sd1, -2'sd1, 2'sd0};
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

>>> rtl/gn_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gn_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  modport source(output valid, coord_x, coord_y, coord_z, input ready);
  modport sink(input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface gn_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] noise_value;
  modport source(output valid, noise_value, input ready);
  modport sink(input valid, noise_value, output ready);
endinterface
`default_nettype wire

>>> rtl/gn_core_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// Arithmetic datapath: all stages advance together on a global enable.
module gn_core_pipe #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] cx,
  input  wire logic signed [31:0] cy,
  input  wire logic signed [31:0] cz,
  input  wire logic [31:0]        seed,
  input  wire logic               mode,
  output      logic signed [15:0] result
);
  import gn_pkg::*;

  // ---------------- stage 1: split coordinates
  logic [31:0] s1_ix, s1_iy, s1_iz;
  logic [15:0] s1_tx, s1_ty, s1_tz;
  logic [31:0] s1_seed;
  logic        s1_mode;

  function automatic logic [15:0] frac16(input logic [31:0] c);
    logic [31:0] f;
    f = c & ((32'd1 << FRAC_BITS) - 32'd1);
    if (FRAC_BITS >= 16) return 16'(f >> (FRAC_BITS - 16));
    else return 16'(f << (16 - FRAC_BITS));
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ix   <= 32'(cx >>> FRAC_BITS);
      s1_iy   <= 32'(cy >>> FRAC_BITS);
      s1_iz   <= 32'(cz >>> FRAC_BITS);
      s1_tx   <= frac16(cx);
      s1_ty   <= frac16(cy);
      s1_tz   <= frac16(cz);
      s1_seed <= seed;
      s1_mode <= mode;
    end
  end

  // ---------------- stage 2: prime products, t^2
  logic [31:0] s2_x0, s2_y0, s2_z0;
  logic [31:0] s2_tx2, s2_ty2, s2_tz2;
  logic [15:0] s2_tx, s2_ty, s2_tz;
  logic [31:0] s2_seed;
  logic        s2_mode;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x0  <= s1_ix * PRIME_X;
      s2_y0  <= s1_iy * PRIME_Y;
      s2_z0  <= s1_iz * PRIME_Z;
      s2_tx2 <= 32'(s1_tx) * 32'(s1_tx);
      s2_ty2 <= 32'(s1_ty) * 32'(s1_ty);
      s2_tz2 <= 32'(s1_tz) * 32'(s1_tz);
      s2_tx  <= s1_tx;
      s2_ty  <= s1_ty;
      s2_tz  <= s1_tz;
      s2_seed <= s1_seed;
      s2_mode <= s1_mode;
    end
  end

  // ---------------- stage 3: corner keys, t^3 and fade polynomial
  logic [31:0] s3_key [8];
  logic [31:0] s3_t3 [3];
  logic [31:0] s3_p16 [3];
  logic [15:0] s3_t [3];
  logic        s3_mode;

  function automatic logic [31:0] poly16(input logic [15:0] t, input logic [31:0] t2);
    logic [47:0] p;
    p = 48'(t2) * 48'd6 + (48'd10 << 32) - (48'(t) << 16) * 48'd15;
    return 32'(p >> 16);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        s3_key[k] <= s2_seed
          ^ ((k & 1) != 0 ? s2_x0 + PRIME_X : s2_x0)
          ^ ((k & 2) != 0 ? s2_y0 + PRIME_Y : s2_y0)
          ^ (s2_mode ? ((k & 4) != 0 ? s2_z0 + PRIME_Z : s2_z0) : 32'd0);
      end
      s3_t3[0] <= 32'((48'(s2_tx2) * 48'(s2_tx)) >> 16);
      s3_t3[1] <= 32'((48'(s2_ty2) * 48'(s2_ty)) >> 16);
      s3_t3[2] <= 32'((48'(s2_tz2) * 48'(s2_tz)) >> 16);
      s3_p16[0] <= poly16(s2_tx, s2_tx2);
      s3_p16[1] <= poly16(s2_ty, s2_ty2);
      s3_p16[2] <= poly16(s2_tz, s2_tz2);
      s3_t[0] <= s2_tx;
      s3_t[1] <= s2_ty;
      s3_t[2] <= s2_tz;
      s3_mode <= s2_mode;
    end
  end

  // ---------------- stage 4: hash multiply, fade product
  logic [31:0] s4_h [8];
  logic [16:0] s4_s [3];
  logic [15:0] s4_t [3];
  logic        s4_mode;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) s4_h[k] <= s3_key[k] * HASH_MUL;
      for (int a = 0; a < 3; a++) begin
        s4_s[a] <= 17'((64'(s3_t3[a]) * 64'(s3_p16[a])) >> 32);
        s4_t[a] <= s3_t[a];
      end
      s4_mode <= s3_mode;
    end
  end

  // ---------------- stage 5: fold, gradient lookup, dot products
  logic signed [17:0] s5_dot [8];
  logic signed [16:0] s5_s [3];
  logic               s5_mode;

  always_ff @(posedge clk) begin
    logic [31:0] f;
    logic signed [17:0] dx, dy, dz;
    grad2_t g2;
    grad3_t g3;
    logic signed [35:0] acc;
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        f  = s4_h[k] ^ (s4_h[k] >> 15);
        dx = (k & 1) != 0 ? $signed({2'b0, s4_t[0]}) - 18'sd65536 : $signed({2'b0, s4_t[0]});
        dy = (k & 2) != 0 ? $signed({2'b0, s4_t[1]}) - 18'sd65536 : $signed({2'b0, s4_t[1]});
        dz = (k & 4) != 0 ? $signed({2'b0, s4_t[2]}) - 18'sd65536 : $signed({2'b0, s4_t[2]});
        if (s4_mode) begin
          g3 = grad3_lookup(f[7:2]);
          s5_dot[k] <= 18'(dx * 18'(g3.gx) + dy * 18'(g3.gy) + dz * 18'(g3.gz));
        end else begin
          g2 = grad2_lookup(f[7:1]);
          acc = 36'(dx) * 36'(g2.gx) + 36'(dy) * 36'(g2.gy);
          s5_dot[k] <= 18'(acc >>> 15);
        end
      end
      for (int a = 0; a < 3; a++) s5_s[a] <= $signed(s4_s[a]);
      s5_mode <= s4_mode;
    end
  end

  function automatic logic signed [19:0] blend(input logic signed [19:0] a,
                                               input logic signed [19:0] b,
                                               input logic signed [16:0] s);
    logic signed [38:0] m;
    m = 39'(b - a) * 39'(s);
    return a + 20'(m >>> 16);
  endfunction

  // ---------------- stage 6: blend along x
  logic signed [19:0] s6_fx [4];
  logic signed [16:0] s6_sy, s6_sz;
  logic               s6_mode;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++)
        s6_fx[j] <= blend(20'(s5_dot[2*j]), 20'(s5_dot[2*j+1]), s5_s[0]);
      s6_sy <= s5_s[1];
      s6_sz <= s5_s[2];
      s6_mode <= s5_mode;
    end
  end

  // ---------------- stage 7: blend along y
  logic signed [19:0] s7_g [2];
  logic signed [16:0] s7_sz;
  logic               s7_mode;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_g[0] <= blend(s6_fx[0], s6_fx[1], s6_sy);
      s7_g[1] <= blend(s6_fx[2], s6_fx[3], s6_sy);
      s7_sz   <= s6_sz;
      s7_mode <= s6_mode;
    end
  end

  // ---------------- stage 8: blend along z (3D only)
  logic signed [19:0] s8_v;
  logic               s8_mode;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_v    <= s7_mode ? blend(s7_g[0], s7_g[1], s7_sz) : s7_g[0];
      s8_mode <= s7_mode;
    end
  end

  // ---------------- stage 9: scale and saturate
  always_ff @(posedge clk) begin
    logic signed [38:0] v;
    logic signed [38:0] r;
    if (en) begin
      v = 39'(s8_v) * $signed({22'd0, s8_mode ? SCALE_3D : SCALE_2D});
      r = v >>> 17;
      if (r > 39'sd32767) result <= 16'sh7fff;
      else if (r < -39'sd32768) result <= 16'sh8000;
      else result <= 16'(r);
    end
  end
endmodule
`default_nettype wire

>>> rtl/gn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid tracking for the datapath and the global stall enable.
module gn_ctrl #(
  parameter int DEPTH = 9
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output      logic in_ready,
  output      logic en,
  output      logic out_valid,
  input  wire logic out_ready
);
  logic [DEPTH-1:0] vld;

  // whole pipe moves unless the last stage holds a result that is blocked
  assign en        = !(vld[DEPTH-1] && !out_ready);
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end
endmodule
`default_nettype wire

>>> rtl/gradient_noise_2d_3d_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Perlin gradient noise (2D or 3D, quintic fade) over a stream of Q16.16 points.
// One point is taken every cycle unless the output stalls; each result is produced by the
// nine-stage arithmetic pipeline (hash multiply, fade products, dot products, three blend
// levels, scaling). An output stall freezes the whole pipeline. Write noise_seed
// (index 0) and dimension_mode (index 1) only while the pipeline is empty.
module gradient_noise_2d_3d_core #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gn_in_if.sink            in_ch,
  gn_out_if.source         out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import gn_pkg::*;

  localparam int DEPTH = 9;

  logic [31:0] noise_seed;
  logic        dimension_mode;
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed     <= '0;
      dimension_mode <= 1'b0;
    end else if (cfg_we) begin
      if ({1'b0, cfg_index} == REG_SEED) noise_seed <= cfg_data;
      if ({1'b0, cfg_index} == REG_MODE) dimension_mode <= cfg_data[0];
    end
  end

  gn_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .en        (en),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  gn_core_pipe #(.FRAC_BITS(COORD_FRAC_BITS)) u_pipe (
    .clk    (clk),
    .en     (en),
    .cx     (in_ch.coord_x),
    .cy     (in_ch.coord_y),
    .cz     (in_ch.coord_z),
    .seed   (noise_seed),
    .mode   (dimension_mode),
    .result (out_ch.noise_value)
  );

  // a blocked result must stall the input side
  a_stall: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  // a blocked result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.noise_value))
    else $error("stalled result changed");

  // no output right after reset
  a_rst: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid after reset");
endmodule
`default_nettype wire

>>> verif/gn_tb_if.sv
`timescale 1ns / 1ps
// Testbench copies are not needed; the RTL interfaces gn_in_if and gn_out_if are used directly.
package gn_tb_types;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;
endpackage

>>> verif/gradient_noise_2d_3d_core_test.sv
`timescale 1ns / 1ps
module gradient_noise_2d_3d_core_test;
  import gn_pkg::*;
  import gn_tb_types::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_ITEMS = 900;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gn_in_if in_ch();
  gn_out_if out_ch();

  gradient_noise_2d_3d_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model copy of the registers
  logic [31:0] seed_q = '0;
  logic mode_q = 1'b0;

  logic signed [15:0] noise_expected[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic void split(input logic [31:0] raw, output logic [31:0] ip,
                                output longint frac);
    ip = $signed(raw) >>> 16;
    frac = raw[15:0];
  endfunction

  function automatic longint fade_q16(input longint t);
    longint t3;
    longint p;
    t3 = (t * t * t) >>> 16;
    p = 6 * t * t + (longint'(10) <<< 32) - 15 * (t <<< 16);
    p = p >>> 16;
    return (t3 * p) >>> 32;
  endfunction

  function automatic longint lerp_q16(input longint a, input longint b, input longint s);
    return a + fshr((b - a) * s, 16);
  endfunction

  function automatic logic [31:0] hash_fold(input logic [31:0] h);
    logic [31:0] m;
    m = h * HASH_MUL;
    return m ^ (m >> 15);
  endfunction

  function automatic longint dot2(input logic [31:0] h, input longint dx, input longint dy);
    int unsigned p;
    int i;
    longint a;
    longint b;
    longint gx;
    longint gy;
    p = (hash_fold(seed_q ^ h) >> 1) & 127;
    if (p < 120) begin
      i = p % 24;
      case (i % 6)
        0: begin a = GA; b = GF; end
        1: begin a = GB; b = GE; end
        2: begin a = GC; b = GD; end
        3: begin a = GD; b = GC; end
        4: begin a = GE; b = GB; end
        default: begin a = GF; b = GA; end
      endcase
      case (i / 6)
        0: begin gx = a; gy = b; end
        1: begin gx = b; gy = -a; end
        2: begin gx = -a; gy = -b; end
        default: begin gx = -b; gy = a; end
      endcase
    end else begin
      case (p & 7)
        0: begin gx = GB; gy = GE; end
        1: begin gx = GE; gy = GB; end
        2: begin gx = GE; gy = -GB; end
        3: begin gx = GB; gy = -GE; end
        4: begin gx = -GB; gy = -GE; end
        5: begin gx = -GE; gy = -GB; end
        6: begin gx = -GE; gy = GB; end
        default: begin gx = -GB; gy = GE; end
      endcase
    end
    return fshr(dx * gx + dy * gy, 15);
  endfunction

  function automatic longint dot3(input logic [31:0] h, input longint dx, input longint dy,
                                  input longint dz);
    int unsigned p;
    int i;
    longint gx;
    longint gy;
    longint gz;
    p = (hash_fold(seed_q ^ h) >> 2) & 63;
    if (p < 60) i = p % 12;
    else begin
      case (p & 3)
        0: i = 8;
        1: i = 1;
        2: i = 9;
        default: i = 3;
      endcase
    end
    gx = (i >= 8) ? ((i % 2 == 0) ? 1 : -1) : (i >= 4 ? ((i % 2 == 0) ? 1 : -1) : 0);
    gy = (i < 4) ? ((i % 2 == 0) ? 1 : -1) : (i < 8 ? 0 : (i < 10 ? 1 : -1));
    gz = (i < 8) ? ((i % 4 < 2) ? 1 : -1) : 0;
    return dx * gx + dy * gy + dz * gz;
  endfunction

  function automatic logic signed [15:0] noise_at(input point_t pt);
    logic [31:0] ix, iy, iz, x0, x1, y0, y1, z0, z1;
    longint tx, ty, tz, sx, sy, sz, v, r, f0, f1, g0, g1;
    split(pt.x, ix, tx);
    split(pt.y, iy, ty);
    split(pt.z, iz, tz);
    x0 = ix * PRIME_X; x1 = x0 + PRIME_X;
    y0 = iy * PRIME_Y; y1 = y0 + PRIME_Y;
    z0 = iz * PRIME_Z; z1 = z0 + PRIME_Z;
    sx = fade_q16(tx); sy = fade_q16(ty); sz = fade_q16(tz);
    if (!mode_q) begin
      f0 = lerp_q16(dot2(x0 ^ y0, tx, ty), dot2(x1 ^ y0, tx - 65536, ty), sx);
      f1 = lerp_q16(dot2(x0 ^ y1, tx, ty - 65536), dot2(x1 ^ y1, tx - 65536, ty - 65536), sx);
      v = lerp_q16(f0, f1, sy) * 93374;
    end else begin
      f0 = lerp_q16(dot3(x0 ^ y0 ^ z0, tx, ty, tz), dot3(x1 ^ y0 ^ z0, tx - 65536, ty, tz), sx);
      f1 = lerp_q16(dot3(x0 ^ y1 ^ z0, tx, ty - 65536, tz),
                    dot3(x1 ^ y1 ^ z0, tx - 65536, ty - 65536, tz), sx);
      g0 = lerp_q16(f0, f1, sy);
      f0 = lerp_q16(dot3(x0 ^ y0 ^ z1, tx, ty, tz - 65536),
                    dot3(x1 ^ y0 ^ z1, tx - 65536, ty, tz - 65536), sx);
      f1 = lerp_q16(dot3(x0 ^ y1 ^ z1, tx, ty - 65536, tz - 65536),
                    dot3(x1 ^ y1 ^ z1, tx - 65536, ty - 65536, tz - 65536), sx);
      g1 = lerp_q16(f0, f1, sy);
      v = lerp_q16(g0, g1, sz) * 63237;
    end
    r = fshr(v, 17);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // directed points; at integer lattice points every offset is zero so the result is 0
  typedef struct {
    point_t pt;
    bit known;
    logic signed [15:0] value;
  } row_t;

  row_t directed[$];

  initial begin
    directed.push_back('{'{32'sh0, 32'sh0, 32'sh0}, 1, 16'sd0});
    directed.push_back('{'{32'sh0001_0000, -32'sh0003_0000, 32'sh7fff_0000}, 1, 16'sd0});
    directed.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1, 16'sd0});
    directed.push_back('{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 0, 0});
    directed.push_back('{'{32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000}, 0, 0});
    directed.push_back('{'{-32'sh0000_0001, -32'sh0000_0001, -32'sh0000_0001}, 0, 0});
    directed.push_back('{'{-32'sh0000_8000, 32'sh0000_4000, -32'sh0001_2000}, 0, 0});
    directed.push_back('{'{32'sh0000_ffff, 32'sh0000_0001, 32'sh0000_ffff}, 0, 0});
    directed.push_back('{'{32'sh8000_ffff, 32'sh7fff_0001, 32'sh0000_0000}, 0, 0});
    directed.push_back('{'{32'sh1234_5678, -32'sh1234_5678, 32'sh5555_aaaa}, 0, 0});
  end

  // a transfer of known value is checked against the typed-in value
  bit known_flags[$];
  logic signed [15:0] known_vals[$];

  task automatic send(input point_t pt, input bit known, input logic signed [15:0] val);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.coord_x <= pt.x;
    in_ch.coord_y <= pt.y;
    in_ch.coord_z <= pt.z;
    do @(posedge clk); while (!in_ch.ready);
    noise_expected.push_back(known ? val : noise_at(pt));
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (noise_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEED[0]) seed_q = val;
    else mode_q = val[0];
  endtask

  function automatic logic [31:0] rand_coord(input int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
      default: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = hold_off ? 200 : $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (noise_expected.size() == 0) report("result with no expectation");
      else begin
        logic signed [15:0] e;
        e = noise_expected.pop_front();
        if (out_ch.noise_value !== e)
          report($sformatf("noise_value got %0d want %0d", out_ch.noise_value, e));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    point_t pt;
    int phase;
    int kind;
    in_ch.valid = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    // directed: both modes, default seed then two extreme seeds
    for (phase = 0; phase < 4; phase++) begin
      if (phase == 1) write_reg(REG_MODE[0], 32'd1);
      if (phase == 2) begin
        write_reg(REG_SEED[0], 32'h8000_0000);
        write_reg(REG_MODE[0], 32'hffff_fffe);
      end
      if (phase == 3) begin
        write_reg(REG_SEED[0], 32'hffff_ffff);
        write_reg(REG_MODE[0], 32'd1);
      end
      foreach (directed[i]) send(directed[i].pt, directed[i].known, directed[i].value);
      drain();
    end
    // random phases with changing settings; one holds off the receiver
    for (phase = 0; phase < 6; phase++) begin
      write_reg(REG_SEED[0], phase == 0 ? 32'h7fff_ffff : $urandom());
      write_reg(REG_MODE[0], phase % 2);
      if (phase == 2) hold_off = 1'b1;
      for (int n = 0; n < RAND_ITEMS / 6; n++) begin
        kind = $urandom_range(0, 2);
        pt.x = rand_coord(kind);
        pt.y = rand_coord(kind);
        pt.z = rand_coord(kind);
        send(pt, 0, 0);
        if (n == 30) hold_off = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
